// ----- sv/asbd_pkg.sv -----
// ----------------------------------------------------------------------------
// asbd_pkg
// Shared types, codes and constants for the async serial bit deframer.
// ----------------------------------------------------------------------------
package asbd_pkg;

    // Frame shift register width and error counter width
    localparam int SHIFT_WIDTH = 16;
    localparam int COUNT_WIDTH = 16;
    localparam int SHAMT_W     = $clog2(SHIFT_WIDTH + 1);

    // Reported counter width
    localparam int REPORT_W    = 16;

    // Operation codes
    localparam logic OP_LINE_BIT = 1'b0;
    localparam logic OP_STATUS   = 1'b1;

    // Result kinds
    localparam logic [1:0] KIND_NONE   = 2'd0;
    localparam logic [1:0] KIND_CHAR   = 2'd1;
    localparam logic [1:0] KIND_STATUS = 2'd2;

    // Parity modes (codes above PARITY_SPACE behave as space)
    localparam logic [2:0] PARITY_NONE  = 3'd0;
    localparam logic [2:0] PARITY_ODD   = 3'd1;
    localparam logic [2:0] PARITY_EVEN  = 3'd2;
    localparam logic [2:0] PARITY_MARK  = 3'd3;
    localparam logic [2:0] PARITY_SPACE = 3'd4;

    // Highest status code that is passed on
    localparam logic [2:0] STATUS_LAST = 3'd5;

    // Character length limits and reset value
    localparam logic [3:0] CHAR_BITS_MIN   = 4'd5;
    localparam logic [3:0] CHAR_BITS_MAX   = 4'd8;
    localparam logic [3:0] CHAR_BITS_RESET = 4'd8;

    // Configuration register indexes
    localparam logic [1:0] CFG_IDX_CHAR_BITS   = 2'd0;
    localparam logic [1:0] CFG_IDX_PARITY_MODE = 2'd1;
    localparam logic [1:0] CFG_IDX_V14_ENABLE  = 2'd2;

    typedef struct packed {
        logic       operation;
        logic       line_bit;
        logic [2:0] status_code;
        logic       clear_parity_count;
        logic       clear_framing_count;
    } item_t;

    typedef struct packed {
        logic [1:0]          result_kind;
        logic [7:0]          char_value;
        logic [2:0]          status_out;
        logic [REPORT_W-1:0] parity_error_count;
        logic [REPORT_W-1:0] framing_error_count;
    } result_t;

    typedef struct packed {
        logic [3:0] char_bits;
        logic [2:0] parity_mode;
        logic       v14_enable;
    } cfg_t;

    // Saturating increment
    function automatic logic [COUNT_WIDTH-1:0] sat_inc(input logic [COUNT_WIDTH-1:0] c);
        return (&c) ? c : c + COUNT_WIDTH'(1);
    endfunction

    // Low bits of a counter as reported, zero extended if narrower
    function automatic logic [REPORT_W-1:0] to_report(input logic [COUNT_WIDTH-1:0] c);
        return REPORT_W'(c);
    endfunction

endpackage

// ----- sv/async_serial_bit_deframer.sv -----
// ----------------------------------------------------------------------------
// async_serial_bit_deframer
// Async serial receive deframer with parity check and V.14 dropped stop bit.
// ----------------------------------------------------------------------------
//
// Channel  | Dir | Handshake                  | Payload
// ---------+-----+----------------------------+------------------------------
// item     | in  | item_valid / item_stall    | item_t: op, bit, status, clears
// result   | out | result_valid / result_stall| result_t: kind, char, counts
// cfg      | in  | cfg_valid / cfg_ready      | cfg_index (2b), cfg_data (4b)
//
// One item per cycle sustained while the result side does not stall. An accepted
// item is held in the input register and is stepped into the result register
// when the framer advances, and its result is then presented from there.
// Every item produces exactly one result.
// rst_n clears the handshake state, framer state, error counters and config
// (8 data bits, no parity, V.14 off).
// item_stall rises only when an item sits in the input register and the
// result register is full and stalled downstream.
// cfg_ready is always high; writes are expected only while the block is idle.
// ----------------------------------------------------------------------------
module async_serial_bit_deframer
    import asbd_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,

    input  logic       item_valid,
    output logic       item_stall,
    input  item_t      item,

    output logic       result_valid,
    input  logic       result_stall,
    output result_t    result,

    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic [1:0] cfg_index,
    input  logic [3:0] cfg_data
);

    // input register
    logic    in_vld_reg, in_vld_next;
    item_t   in_item_reg;

    // result register
    logic    out_vld_reg, out_vld_next;
    result_t out_item_reg;

    cfg_t    cfg;
    result_t step_result;
    logic    advance;
    logic    accept;

    // step the framer when the result register is free or being drained
    assign advance    = in_vld_reg && (!out_vld_reg || !result_stall);
    assign item_stall = in_vld_reg && !advance;
    assign accept     = item_valid && !item_stall;
    assign cfg_ready  = 1'b1;

    asbd_cfg u_cfg
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (cfg_valid && cfg_ready),
        .wr_index (cfg_index),
        .wr_data  (cfg_data),
        .cfg      (cfg)
    );

    asbd_core u_core
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .step   (advance),
        .item   (in_item_reg),
        .cfg    (cfg),
        .result (step_result)
    );

    always_comb
    begin
        if (accept)
            in_vld_next = 1'b1;
        else if (advance)
            in_vld_next = 1'b0;
        else
            in_vld_next = in_vld_reg;

        if (advance)
            out_vld_next = 1'b1;
        else if (!result_stall)
            out_vld_next = 1'b0;
        else
            out_vld_next = out_vld_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            in_vld_reg  <= in_vld_next;
            out_vld_reg <= out_vld_next;
        end
    end

    // payload registers, no reset
    always_ff @(posedge clk)
    begin
        if (accept)
            in_item_reg <= item;
        if (advance)
            out_item_reg <= step_result;
    end

    assign result_valid = out_vld_reg;
    assign result       = out_item_reg;

endmodule

// ----- sv/asbd_cfg.sv -----
// ----------------------------------------------------------------------------
// asbd_cfg
// Configuration register file: data bits, parity mode, V.14 enable.
// ----------------------------------------------------------------------------
module asbd_cfg
    import asbd_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       wr_en,
    input  logic [1:0] wr_index,
    input  logic [3:0] wr_data,
    output cfg_t       cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            case (wr_index)
                CFG_IDX_CHAR_BITS:   cfg_next.char_bits   = wr_data;
                CFG_IDX_PARITY_MODE: cfg_next.parity_mode = wr_data[2:0];
                CFG_IDX_V14_ENABLE:  cfg_next.v14_enable  = wr_data[0];
                default:             cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.char_bits   <= CHAR_BITS_RESET;
            cfg_reg.parity_mode <= PARITY_NONE;
            cfg_reg.v14_enable  <= 1'b0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

// ----- sv/asbd_core.sv -----
// ----------------------------------------------------------------------------
// asbd_core
// Framer state and one-item step logic: hunt, shift, stop bit check.
// ----------------------------------------------------------------------------
module asbd_core
    import asbd_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    step,
    input  item_t   item,
    input  cfg_t    cfg,
    output result_t result
);

    logic [3:0]             bit_pos_reg,  bit_pos_next;
    logic [SHIFT_WIDTH-1:0] shift_reg,    shift_next;
    logic [COUNT_WIDTH-1:0] par_err_reg,  par_err_next;
    logic [COUNT_WIDTH-1:0] frm_err_reg,  frm_err_next;

    logic [3:0]             eff_bits;
    logic                   has_par;
    logic [3:0]             total;
    logic [SHAMT_W-1:0]     shamt;
    logic [SHIFT_WIDTH-1:0] masked;
    logic [SHIFT_WIDTH-1:0] data;
    logic [7:0]             data8;
    logic                   want;
    logic                   got;
    logic [COUNT_WIDTH-1:0] par_rep;
    logic [COUNT_WIDTH-1:0] frm_rep;

    always_comb
    begin
        if (cfg.char_bits < CHAR_BITS_MIN)
            eff_bits = CHAR_BITS_MIN;
        else if (cfg.char_bits > CHAR_BITS_MAX)
            eff_bits = CHAR_BITS_MAX;
        else
            eff_bits = cfg.char_bits;
    end

    assign has_par = (cfg.parity_mode != PARITY_NONE);
    assign total   = eff_bits + {3'd0, has_par};
    assign shamt   = SHAMT_W'(SHIFT_WIDTH) - SHAMT_W'(total);
    assign got     = shift_reg[SHIFT_WIDTH-1];
    assign masked  = has_par ? {1'b0, shift_reg[SHIFT_WIDTH-2:0]} : shift_reg;
    assign data    = masked >> shamt;
    assign data8   = data[7:0];

    always_comb
    begin
        case (cfg.parity_mode)
            PARITY_ODD:  want = ~(^data8);
            PARITY_EVEN: want = ^data8;
            PARITY_MARK: want = 1'b1;
            default:     want = 1'b0;
        endcase
    end

    always_comb
    begin
        bit_pos_next = bit_pos_reg;
        shift_next   = shift_reg;
        par_rep      = par_err_reg;
        frm_rep      = frm_err_reg;
        result       = '0;

        if (item.operation == OP_STATUS)
        begin
            if (item.status_code <= STATUS_LAST)
            begin
                result.result_kind = KIND_STATUS;
                result.status_out  = item.status_code;
                bit_pos_next       = 4'd0;
                shift_next         = '0;
            end
        end
        else if (bit_pos_reg == 4'd0)
        begin
            // hunting: a zero is the start bit
            bit_pos_next = {3'd0, ~item.line_bit};
            shift_next   = '0;
        end
        else if (bit_pos_reg <= total)
        begin
            // data and parity bits enter at the top, LSB first
            shift_next   = {item.line_bit, shift_reg[SHIFT_WIDTH-1:1]};
            bit_pos_next = bit_pos_reg + 4'd1;
        end
        else if (!item.line_bit && !cfg.v14_enable)
        begin
            frm_rep      = sat_inc(frm_err_reg);
            bit_pos_next = 4'd0;
        end
        else
        begin
            // stop bit, or V.14 dropped stop bit
            if (has_par && (got != want))
            begin
                par_rep = sat_inc(par_err_reg);
            end
            else
            begin
                result.result_kind = KIND_CHAR;
                result.char_value  = data8;
            end
            if (item.line_bit)
            begin
                bit_pos_next = 4'd0;
            end
            else
            begin
                bit_pos_next = 4'd1;
                shift_next   = '0;
            end
        end

        result.parity_error_count  = to_report(par_rep);
        result.framing_error_count = to_report(frm_rep);

        par_err_next = item.clear_parity_count  ? '0 : par_rep;
        frm_err_next = item.clear_framing_count ? '0 : frm_rep;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bit_pos_reg <= 4'd0;
            shift_reg   <= '0;
            par_err_reg <= '0;
            frm_err_reg <= '0;
        end
        else if (step)
        begin
            bit_pos_reg <= bit_pos_next;
            shift_reg   <= shift_next;
            par_err_reg <= par_err_next;
            frm_err_reg <= frm_err_next;
        end
    end

endmodule
